### rtl/core/ppp_dfr_pkg.sv
// Types, codes and the FCS-16 byte update shared by the PPP async HDLC deframer.
// No dependencies; every other file of the deframer imports this package.
`default_nettype none

package ppp_dfr_pkg;

  // Special octets of the async HDLC stream
  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [7:0]  EscByte  = 8'h7D;
  localparam logic [7:0]  EscXor   = 8'h20;

  // FCS-16 as per the PPP async framing spec
  localparam logic [15:0] FcsStart = 16'hFFFF;
  localparam logic [15:0] FcsGood  = 16'hF0B8;
  localparam logic [15:0] FcsPoly  = 16'h8408;

  // Shortest frame accepted as good, FCS included
  localparam int unsigned MinFrame = 4;

  // Header octets
  localparam logic [7:0]  AddrAllStations = 8'hFF;
  localparam logic [7:0]  CtrlUi          = 8'h03;

  // Reset value of the frame length limit
  localparam logic [11:0] MaxLenReset = 12'd1536;

  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_SYNC  = 2'd1,
    MODE_FRAME = 2'd2
  } sync_mode_e;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_FCS  = 2'd1,
    ST_SHORT    = 2'd2,
    ST_OVERFLOW = 2'd3
  } frame_status_e;

  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] link_tag;
  } rx_item_t;

  typedef struct packed {
    kind_e         kind;
    logic [7:0]    payload_byte;
    frame_status_e frame_status;
    logic [11:0]   frame_length;
    logic [15:0]   protocol;
    logic [2:0]    header_length;
    logic [1:0]    ac_length;
    logic [7:0]    frame_tag;
  } rx_result_t;

  // Fold one octet into the reflected FCS-16
  function automatic logic [15:0] fcs16_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] f;
    f = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (f[0]) begin
        f = (f >> 1) ^ FcsPoly;
      end else begin
        f = f >> 1;
      end
    end
    return f;
  endfunction

endpackage

`default_nettype wire

### rtl/core/ppp_async_hdlc_deframer_top.sv
// Top level of the PPP async HDLC deframer: input register, deframing core and
// result register. Depends on ppp_dfr_pkg, ppp_dfr_in_reg, ppp_dfr_core, ppp_dfr_out_reg.
`default_nettype none

// The deframer takes one raw received byte per cycle while the sink is ready
// and answers it with at most one result, which the result register presents
// once the core has stepped the byte: a payload byte (held back by two octets
// so the FCS never leaves) or a frame-end report with status, length, parsed
// header and the closing flag's link tag. The rate is set by the combinational
// octet step of the core (escape strip, FCS-16 update, counter compare) that
// sits between the input register and the result register; with the sink
// ready a new byte is accepted on every clock. in_ready_o follows out_ready_i
// combinationally through both registers. The frame limit register takes a
// write on any cycle and should be written only while the block is idle.
module ppp_async_hdlc_deframer_top
  import ppp_dfr_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire rx_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output rx_result_t       out_data_o
);

  logic       item_valid;
  rx_item_t   item;
  logic       res_ready;
  logic       res_valid;
  rx_result_t res;

  assign cfg_ready_o = 1'b1;

  // Hold the accepted byte transaction
  ppp_dfr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (item_valid),
    .ready_i (res_ready),
    .data_o  (item)
  );

  // Process the held byte when the result register can take its outcome
  ppp_dfr_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (item_valid && res_ready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold the result until the sink takes it
  ppp_dfr_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .ready_o (res_ready),
    .data_i  (res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/core/ppp_dfr_in_reg.sv
// Input register of the PPP deframer: holds one received byte transaction.
// Depends on ppp_dfr_pkg for the input item type.
`default_nettype none

module ppp_dfr_in_reg
  import ppp_dfr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire rx_item_t data_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output rx_item_t      data_o
);

  logic     valid_q;
  rx_item_t data_q;

  // Take a new transaction when empty or when the held one moves on
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ppp_dfr_out_reg.sv
// Result register of the PPP deframer: holds one result until the sink takes it.
// Depends on ppp_dfr_pkg for the result item type.
`default_nettype none

module ppp_dfr_out_reg
  import ppp_dfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire rx_result_t data_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output rx_result_t      data_o
);

  logic       valid_q;
  rx_result_t data_q;

  // Free when empty or when the sink takes the held transaction this cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ppp_dfr_core.sv
// Deframing datapath: sync state machine, escape removal, FCS-16, byte delay
// line, header capture and frame-end report. Depends on ppp_dfr_pkg.
`default_nettype none

module ppp_dfr_core
  import ppp_dfr_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        step_i,
  input  wire rx_item_t    item_i,
  output logic             res_valid_o,
  output rx_result_t       res_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME + 1);
  localparam int unsigned LimW = (CntW > 12) ? CntW : 12;

  sync_mode_e    mode_q, mode_d;
  logic          esc_q, esc_d;
  logic [15:0]   fcs_q, fcs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [11:0]   max_len_q;
  logic [7:0]    head_q [4];
  logic [7:0]    dly_q [2];

  logic [7:0]      b, ub;
  logic [LimW-1:0] cnt_ext, limit, cfg_ext, max_ext, len_ext;
  logic            store, framing;
  logic            ac_present;
  logic [7:0]      sel0, sel1;
  rx_result_t      res;
  logic            res_valid;

  assign b       = item_i.rx_byte;
  assign cnt_ext = LimW'(cnt_q);
  assign cfg_ext = LimW'(max_len_q);
  assign max_ext = LimW'(MAX_FRAME);
  assign limit   = (cfg_ext > max_ext) ? max_ext : cfg_ext;
  assign ub      = esc_q ? (b ^ EscXor) : b;
  assign len_ext = (cnt_ext >= LimW'(2)) ? (cnt_ext - LimW'(2)) : '0;

  // Parse the header from the first four stored octets
  assign ac_present = (head_q[0] == AddrAllStations) && (head_q[1] == CtrlUi);
  assign sel0       = ac_present ? head_q[2] : head_q[0];
  assign sel1       = ac_present ? head_q[3] : head_q[1];

  // Next state and result of the item held in the input register
  always_comb begin
    mode_d    = mode_q;
    esc_d     = esc_q;
    fcs_d     = fcs_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    framing   = 1'b0;
    store     = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    unique case (mode_q)
      MODE_FRAME: begin
        if (b == FlagByte) begin
          // Close the frame and report
          res_valid          = 1'b1;
          res.kind           = KIND_FRAME_END;
          res.frame_tag      = item_i.link_tag;
          res.frame_length   = len_ext[11:0];
          if (ovf_q) begin
            res.frame_status = ST_OVERFLOW;
          end else if (fcs_q != FcsGood) begin
            res.frame_status = ST_BAD_FCS;
          end else if (cnt_ext < LimW'(MinFrame)) begin
            res.frame_status = ST_SHORT;
          end else begin
            res.frame_status = ST_GOOD;
          end
          if (cnt_ext >= LimW'(MinFrame)) begin
            res.ac_length = ac_present ? 2'd2 : 2'd0;
            if (sel0[0]) begin
              res.header_length = ac_present ? 3'd3 : 3'd1;
              res.protocol      = {8'h00, sel0};
            end else begin
              res.header_length = ac_present ? 3'd4 : 3'd2;
              res.protocol      = {sel0, sel1};
            end
          end
          mode_d = MODE_SYNC;
          esc_d  = 1'b0;
          fcs_d  = FcsStart;
          cnt_d  = '0;
          ovf_d  = 1'b0;
        end else begin
          framing = 1'b1;
        end
      end
      MODE_SYNC: begin
        if (b != FlagByte) begin
          mode_d  = MODE_FRAME;
          framing = 1'b1;
        end
      end
      default: begin
        // Hunt, and the unused code, wait for a flag
        if (b == FlagByte) begin
          mode_d = MODE_SYNC;
        end
      end
    endcase

    // Strip escapes, store in-limit octets, drop the rest
    if (framing) begin
      if (b == EscByte && !esc_q) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        if (cnt_ext < limit) begin
          store = 1'b1;
          fcs_d = fcs16_update(fcs_q, ub);
          cnt_d = cnt_q + CntW'(1);
          if (cnt_ext >= LimW'(2)) begin
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = dly_q[0];
          end
        end else begin
          fcs_d = FcsStart;
          ovf_d = 1'b1;
        end
      end
    end
  end

  assign res_valid_o = step_i && res_valid;
  assign res_o       = res;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HUNT;
      esc_q  <= 1'b0;
      fcs_q  <= FcsStart;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
      fcs_q  <= fcs_d;
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
    end
  end

  // Frame length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Advance the two-octet delay line and capture the header octets
  always_ff @(posedge clk_i) begin
    if (step_i && store) begin
      dly_q[0] <= dly_q[1];
      dly_q[1] <= ub;
      for (int i = 0; i < 4; i++) begin
        if (cnt_ext < LimW'(MinFrame) && cnt_q[1:0] == 2'(i)) begin
          head_q[i] <= ub;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ext <= max_ext)
    else $error("stored count beyond the frame limit");

  a_esc_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> mode_q == MODE_FRAME)
    else $error("escape pending outside a frame");

  a_payload_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res.kind == KIND_PAYLOAD |=> cnt_q >= CntW'(3))
    else $error("payload octet sent before two octets were held back");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res.kind == KIND_FRAME_END
      |=> mode_q == MODE_SYNC && cnt_q == '0 && !ovf_q && fcs_q == FcsStart)
    else $error("frame state not cleared after a frame end");
`endif

endmodule

`default_nettype wire
